/* src/nvq_pkg.sv */
`timescale 1ns / 1ps

package nvq_pkg;

   // request kind codes
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_CPL   = 2'd2
   } req_kind_type;

   // result kind codes
   localparam logic RES_SUB = 1'b0;
   localparam logic RES_CPL = 1'b1;

   // command opcodes
   localparam logic [7:0] OPC_READ  = 8'd2;
   localparam logic [7:0] OPC_WRITE = 8'd1;

   // completion dword 3 layout
   localparam int PHASE_BIT  = 16;
   localparam int SCODE_LSB  = 17;
   localparam int SCODE_MSB  = 24;
   localparam int STYPE_LSB  = 25;
   localparam int STYPE_MSB  = 27;

   // field widths
   localparam int KIND_W  = 2;
   localparam int LBA_W   = 64;
   localparam int CNT_W   = 16;
   localparam int ADDR_W  = 64;
   localparam int DW_W    = 32;
   localparam int PTR_OUT_W = 6;
   localparam int OPC_W   = 8;
   localparam int CID_W   = 16;
   localparam int NS_W    = 32;
   localparam int STYPE_W = 3;
   localparam int SCODE_W = 8;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_NAMESPACE_ID = 3'd0;
   localparam logic [NS_W-1:0] NAMESPACE_RESET = 32'd1;

   // queue between front and back
   localparam int FIFO_DEPTH = 2;

   // classified work item
   typedef struct packed {
      logic               is_cpl;
      logic [OPC_W-1:0]   opcode;
      logic [LBA_W-1:0]   lba;
      logic [CNT_W-1:0]   cnt_m1;
      logic [ADDR_W-1:0]  buf_addr;
      logic               phase;
      logic [STYPE_W-1:0] stype;
      logic [SCODE_W-1:0] scode;
   } entry_type;

endpackage

/* src/nvq_req_if.sv */
`timescale 1ns / 1ps

interface nvq_req_if;
   logic                          valid;
   logic                          ready;
   logic [nvq_pkg::KIND_W-1:0]    kind;
   logic [nvq_pkg::LBA_W-1:0]     start_lba;
   logic [nvq_pkg::CNT_W-1:0]     block_count;
   logic [nvq_pkg::ADDR_W-1:0]    buffer_addr;
   logic [nvq_pkg::DW_W-1:0]      completion_status;

   modport source (
      output valid, kind, start_lba, block_count, buffer_addr, completion_status,
      input  ready
   );

   modport sink (
      input  valid, kind, start_lba, block_count, buffer_addr, completion_status,
      output ready
   );
endinterface

/* src/nvq_rsp_if.sv */
`timescale 1ns / 1ps

interface nvq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [nvq_pkg::PTR_OUT_W-1:0]  slot;
   logic [nvq_pkg::OPC_W-1:0]      opcode;
   logic [nvq_pkg::CID_W-1:0]      command_id;
   logic [nvq_pkg::NS_W-1:0]       entry_namespace;
   logic [nvq_pkg::LBA_W-1:0]      entry_lba;
   logic [nvq_pkg::CNT_W-1:0]      count_minus_one;
   logic [nvq_pkg::ADDR_W-1:0]     data_pointer;
   logic [nvq_pkg::PTR_OUT_W-1:0]  doorbell_value;
   logic                           success;
   logic [nvq_pkg::STYPE_W-1:0]    status_type;
   logic [nvq_pkg::SCODE_W-1:0]    status_code;

   modport source (
      output valid, result_kind, slot, opcode, command_id, entry_namespace, entry_lba,
             count_minus_one, data_pointer, doorbell_value, success, status_type,
             status_code,
      input  ready
   );

   modport sink (
      input  valid, result_kind, slot, opcode, command_id, entry_namespace, entry_lba,
             count_minus_one, data_pointer, doorbell_value, success, status_type,
             status_code,
      output ready
   );
endinterface

/* src/nvq_front.sv */
`timescale 1ns / 1ps

module nvq_front (
   nvq_req_if.sink             req,
   input  logic                q_full,
   output logic                q_push,
   output nvq_pkg::entry_type  q_entry
);

   logic keep;

   // accept whenever the queue has room
   assign req.ready = !q_full;

   // classify the request and unpack its fields
   always_comb begin
      keep    = 1'b0;
      q_entry = '0;
      q_entry.lba      = req.start_lba;
      q_entry.cnt_m1   = req.block_count - nvq_pkg::CNT_W'(1);
      q_entry.buf_addr = req.buffer_addr;
      q_entry.phase    = req.completion_status[nvq_pkg::PHASE_BIT];
      q_entry.stype    = req.completion_status[nvq_pkg::STYPE_MSB:nvq_pkg::STYPE_LSB];
      q_entry.scode    = req.completion_status[nvq_pkg::SCODE_MSB:nvq_pkg::SCODE_LSB];
      case (req.kind)
         nvq_pkg::REQ_READ: begin
            keep           = 1'b1;
            q_entry.is_cpl = 1'b0;
            q_entry.opcode = nvq_pkg::OPC_READ;
         end
         nvq_pkg::REQ_WRITE: begin
            keep           = 1'b1;
            q_entry.is_cpl = 1'b0;
            q_entry.opcode = nvq_pkg::OPC_WRITE;
         end
         nvq_pkg::REQ_CPL: begin
            keep           = 1'b1;
            q_entry.is_cpl = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // unused kind code is taken and dropped here
   assign q_push = req.valid && req.ready && keep;

endmodule

/* src/nvq_fifo.sv */
`timescale 1ns / 1ps

module nvq_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nvq_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output nvq_pkg::entry_type  head_entry
);

   localparam int PTR_W = $clog2(nvq_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(nvq_pkg::FIFO_DEPTH + 1);

   nvq_pkg::entry_type mem_ff [nvq_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(nvq_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(nvq_pkg::FIFO_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(nvq_pkg::FIFO_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/nvq_back.sv */
`timescale 1ns / 1ps

module nvq_back #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  nvq_pkg::entry_type         q_entry,
   output logic                       q_pop,
   input  logic [nvq_pkg::NS_W-1:0]   namespace_id,
   nvq_rsp_if.source                  rsp
);

   localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic             phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0] tail_next, head_next;
   logic             load, produce;

   logic                          kind_ff;
   logic [nvq_pkg::PTR_OUT_W-1:0] slot_ff, slot_in;
   logic [nvq_pkg::OPC_W-1:0]     opcode_ff;
   logic [nvq_pkg::NS_W-1:0]      ns_ff;
   logic [nvq_pkg::LBA_W-1:0]     lba_ff;
   logic [nvq_pkg::CNT_W-1:0]     cnt_ff;
   logic [nvq_pkg::ADDR_W-1:0]    buf_ff;
   logic [nvq_pkg::PTR_OUT_W-1:0] bell_ff, bell_in;
   logic                          ok_ff;
   logic [nvq_pkg::STYPE_W-1:0]   stype_ff;
   logic [nvq_pkg::SCODE_W-1:0]   scode_ff;

   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + PTR_W'(1);
   assign head_next = (head_ff == LAST) ? '0 : head_ff + PTR_W'(1);

   // take the queue head when the output register is free
   assign load  = q_valid && (!rsp_valid_ff || rsp.ready);
   assign q_pop = load;

   // a completion with the wrong phase is not yet posted and is dropped
   assign produce = load && (!q_entry.is_cpl || (q_entry.phase == phase_ff));

   // pointer and phase tracking
   always_comb begin
      tail_in  = tail_ff;
      head_in  = head_ff;
      phase_in = phase_ff;
      slot_in  = nvq_pkg::PTR_OUT_W'(tail_ff);
      bell_in  = nvq_pkg::PTR_OUT_W'(tail_next);
      if (q_entry.is_cpl) begin
         slot_in = nvq_pkg::PTR_OUT_W'(head_ff);
         bell_in = nvq_pkg::PTR_OUT_W'(head_next);
      end
      if (produce) begin
         if (q_entry.is_cpl) begin
            head_in = head_next;
            if (head_next == '0) begin
               phase_in = !phase_ff;
            end
         end else begin
            tail_in = tail_next;
         end
      end
   end

   assign rsp_valid_in = load ? produce : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         head_ff      <= '0;
         phase_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register, fields without meaning are zero
   always_ff @(posedge clock) begin
      if (produce) begin
         slot_ff <= slot_in;
         bell_ff <= bell_in;
         if (q_entry.is_cpl) begin
            kind_ff   <= nvq_pkg::RES_CPL;
            opcode_ff <= '0;
            ns_ff     <= '0;
            lba_ff    <= '0;
            cnt_ff    <= '0;
            buf_ff    <= '0;
            ok_ff     <= (q_entry.stype == '0) && (q_entry.scode == '0);
            stype_ff  <= q_entry.stype;
            scode_ff  <= q_entry.scode;
         end else begin
            kind_ff   <= nvq_pkg::RES_SUB;
            opcode_ff <= q_entry.opcode;
            ns_ff     <= namespace_id;
            lba_ff    <= q_entry.lba;
            cnt_ff    <= q_entry.cnt_m1;
            buf_ff    <= q_entry.buf_addr;
            ok_ff     <= 1'b0;
            stype_ff  <= '0;
            scode_ff  <= '0;
         end
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result_kind     = kind_ff;
   assign rsp.slot            = slot_ff;
   assign rsp.opcode          = opcode_ff;
   assign rsp.command_id      = nvq_pkg::CID_W'(opcode_ff);
   assign rsp.entry_namespace = ns_ff;
   assign rsp.entry_lba       = lba_ff;
   assign rsp.count_minus_one = cnt_ff;
   assign rsp.data_pointer    = buf_ff;
   assign rsp.doorbell_value  = bell_ff;
   assign rsp.success         = ok_ff;
   assign rsp.status_type     = stype_ff;
   assign rsp.status_code     = scode_ff;

endmodule

/* src/nvme_io_queue_engine.sv */
`timescale 1ns / 1ps
// A result is registered: an accepted request passes through the queue and then the
// output register of the back stage. Throughput: one transaction per cycle while the
// result side is ready; a two-entry queue separates request and result sides.
// Reset (synchronous, active high): tail and head zero, expected phase one,
// namespace id one, queue and output register empty.

module nvme_io_queue_engine #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   nvq_req_if.sink                             req,
   nvq_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nvq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [nvq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nvq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic                       q_push, q_full, q_pop, q_valid;
   nvq_pkg::entry_type         push_entry, head_entry;
   logic [nvq_pkg::NS_W-1:0]   ns_ff, ns_in;
   logic                       csr_wr;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ns_in = ns_ff;
      if (csr_wr && (csr_paddr == nvq_pkg::CSR_NAMESPACE_ID)) begin
         ns_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff <= nvq_pkg::NAMESPACE_RESET;
      end else begin
         ns_ff <= ns_in;
      end
   end

   assign csr_prdata = (csr_paddr == nvq_pkg::CSR_NAMESPACE_ID) ? ns_ff : '0;

   // classify incoming transactions
   nvq_front u_front (
      .req     (req),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   // decoupling queue
   nvq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   // queue pointers and result formatting
   nvq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (head_entry),
      .q_pop        (q_pop),
      .namespace_id (ns_ff),
      .rsp          (rsp)
   );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH = 64;
   localparam logic [nvq_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT = 2000;
   localparam int PRINT_CAP = 40;

   // one request transaction as driven on the request channel
   typedef struct packed {
      logic [nvq_pkg::KIND_W-1:0] kind;
      logic [nvq_pkg::LBA_W-1:0]  lba;
      logic [nvq_pkg::CNT_W-1:0]  blocks;
      logic [nvq_pkg::ADDR_W-1:0] buf_addr;
      logic [nvq_pkg::DW_W-1:0]   dw3;
   } host_item_type;

   // one result transaction as expected on the result channel
   typedef struct packed {
      logic                          result_kind;
      logic [nvq_pkg::PTR_OUT_W-1:0] slot;
      logic [nvq_pkg::OPC_W-1:0]     opcode;
      logic [nvq_pkg::CID_W-1:0]     command_id;
      logic [nvq_pkg::NS_W-1:0]      entry_namespace;
      logic [nvq_pkg::LBA_W-1:0]     entry_lba;
      logic [nvq_pkg::CNT_W-1:0]     count_minus_one;
      logic [nvq_pkg::ADDR_W-1:0]    data_pointer;
      logic [nvq_pkg::PTR_OUT_W-1:0] doorbell_value;
      logic                          success;
      logic [nvq_pkg::STYPE_W-1:0]   status_type;
      logic [nvq_pkg::SCODE_W-1:0]   status_code;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [nvq_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [nvq_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [nvq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   nvq_req_if req_bus ();
   nvq_rsp_if rsp_bus ();

   // queue pair state as the host sees it
   int unsigned  sq_tail = 0;
   int unsigned  cq_head = 0;
   bit           cq_phase = 1'b1;
   logic [nvq_pkg::NS_W-1:0] ns_reg = nvq_pkg::NAMESPACE_RESET;

   queue_result_type expected_entries[$];

   bit src_idle_on;
   bit sink_idle_on;
   int idle_cycles = 0;

   int n_errors = 0;
   int n_items = 0;
   int n_sub = 0;
   int n_cpl = 0;
   int n_failed = 0;
   int n_stale = 0;
   int n_ignored = 0;
   int n_flips = 0;
   int n_ns_writes = 0;

   nvme_io_queue_engine #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // host-side view of one accepted request: updates pointers, gives the entry, returns whether there is one
   function automatic bit predict_queue_step(input host_item_type it,
                                             output queue_result_type res);
      int unsigned slot_now;
      res = '0;
      case (it.kind)
         nvq_pkg::REQ_READ, nvq_pkg::REQ_WRITE: begin
            slot_now = sq_tail;
            sq_tail = (sq_tail == DEPTH - 1) ? 0 : sq_tail + 1;
            res.result_kind     = nvq_pkg::RES_SUB;
            res.slot            = slot_now[nvq_pkg::PTR_OUT_W-1:0];
            res.opcode          = (it.kind == nvq_pkg::REQ_READ) ? nvq_pkg::OPC_READ :
                                  nvq_pkg::OPC_WRITE;
            res.command_id      = {8'd0, res.opcode};
            res.entry_namespace = ns_reg;
            res.entry_lba       = it.lba;
            res.count_minus_one = it.blocks - 16'd1;
            res.data_pointer    = it.buf_addr;
            res.doorbell_value  = sq_tail[nvq_pkg::PTR_OUT_W-1:0];
            n_sub++;
            return 1'b1;
         end
         nvq_pkg::REQ_CPL: begin
            // not yet posted by the controller: nothing happens
            if (it.dw3[nvq_pkg::PHASE_BIT] != cq_phase) begin
               n_stale++;
               return 1'b0;
            end
            slot_now = cq_head;
            cq_head = (cq_head == DEPTH - 1) ? 0 : cq_head + 1;
            if (cq_head == 0) begin
               cq_phase = !cq_phase;
               n_flips++;
            end
            res.result_kind    = nvq_pkg::RES_CPL;
            res.slot           = slot_now[nvq_pkg::PTR_OUT_W-1:0];
            res.doorbell_value = cq_head[nvq_pkg::PTR_OUT_W-1:0];
            res.status_type    = it.dw3[nvq_pkg::STYPE_MSB:nvq_pkg::STYPE_LSB];
            res.status_code    = it.dw3[nvq_pkg::SCODE_MSB:nvq_pkg::SCODE_LSB];
            res.success        = (res.status_type == '0) && (res.status_code == '0);
            if (!res.success)
               n_failed++;
            n_cpl++;
            return 1'b1;
         end
         default: begin
            n_ignored++;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic host_item_type make_item(input logic [nvq_pkg::KIND_W-1:0] kind,
                                               input logic [nvq_pkg::LBA_W-1:0] lba,
                                               input logic [nvq_pkg::CNT_W-1:0] blocks,
                                               input logic [nvq_pkg::ADDR_W-1:0] addr,
                                               input logic [nvq_pkg::DW_W-1:0] dw3);
      host_item_type it;
      it.kind = kind;
      it.lba = lba;
      it.blocks = blocks;
      it.buf_addr = addr;
      it.dw3 = dw3;
      return it;
   endfunction

   // pick chooses the class: read, write, posted completion, stale completion, reserved
   function automatic host_item_type random_item(input int unsigned pick);
      host_item_type it;
      it.lba = {$urandom, $urandom};
      it.buf_addr = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0: it.blocks = 16'h0000;
         1: it.blocks = 16'h0001;
         2: it.blocks = 16'hFFFF;
         default: it.blocks = 16'($urandom_range(0, 65535));
      endcase
      it.dw3 = $urandom;
      // mostly clean status so that success is common
      if ($urandom_range(0, 9) < 7)
         it.dw3[nvq_pkg::STYPE_MSB:nvq_pkg::SCODE_LSB] = '0;
      if (pick < 22)
         it.kind = nvq_pkg::REQ_READ;
      else if (pick < 44)
         it.kind = nvq_pkg::REQ_WRITE;
      else if (pick < 84) begin
         it.kind = nvq_pkg::REQ_CPL;
         it.dw3[nvq_pkg::PHASE_BIT] = cq_phase;
      end else if (pick < 94) begin
         it.kind = nvq_pkg::REQ_CPL;
         it.dw3[nvq_pkg::PHASE_BIT] = !cq_phase;
      end else
         it.kind = KIND_RESERVED;
      return it;
   endfunction

   // drive one request transaction and record what it should produce
   task automatic issue_host_item(input host_item_type it);
      int gap;
      queue_result_type res;
      if (src_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.kind              <= it.kind;
      req_bus.start_lba         <= it.lba;
      req_bus.block_count       <= it.blocks;
      req_bus.buffer_addr       <= it.buf_addr;
      req_bus.completion_status <= it.dw3;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_queue_step(it, res))
         expected_entries.push_back(res);
      n_items++;
   endtask

   // stop sending and wait for every outstanding entry, then let the pipe settle
   task automatic drain_queue_pair();
      req_bus.valid <= 1'b0;
      while (expected_entries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write of the namespace register
   task automatic write_namespace(input logic [nvq_pkg::NS_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= nvq_pkg::CSR_NAMESPACE_ID;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ns_reg = value;
      n_ns_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      if (n_errors < PRINT_CAP)
         $display("mismatch %s: got %h expected %h at %0t ns", what, got, want, $realtime);
      n_errors++;
   endtask

   // result channel stalls
   always begin : result_backpressure
      @(posedge clock);
      if (sink_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest expected entry
   always @(posedge clock) begin : result_checker
      queue_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_entries.size() == 0) begin
            log_mismatch("result with nothing outstanding", 64'(rsp_bus.slot), '0);
         end else begin
            want = expected_entries.pop_front();
            if (rsp_bus.result_kind !== want.result_kind)
               log_mismatch("result_kind", 64'(rsp_bus.result_kind),
                            64'(want.result_kind));
            if (rsp_bus.slot !== want.slot)
               log_mismatch("slot", 64'(rsp_bus.slot), 64'(want.slot));
            if (rsp_bus.opcode !== want.opcode)
               log_mismatch("opcode", 64'(rsp_bus.opcode), 64'(want.opcode));
            if (rsp_bus.command_id !== want.command_id)
               log_mismatch("command_id", 64'(rsp_bus.command_id), 64'(want.command_id));
            if (rsp_bus.entry_namespace !== want.entry_namespace)
               log_mismatch("entry_namespace", 64'(rsp_bus.entry_namespace),
                            64'(want.entry_namespace));
            if (rsp_bus.entry_lba !== want.entry_lba)
               log_mismatch("entry_lba", rsp_bus.entry_lba, want.entry_lba);
            if (rsp_bus.count_minus_one !== want.count_minus_one)
               log_mismatch("count_minus_one", 64'(rsp_bus.count_minus_one),
                            64'(want.count_minus_one));
            if (rsp_bus.data_pointer !== want.data_pointer)
               log_mismatch("data_pointer", rsp_bus.data_pointer, want.data_pointer);
            if (rsp_bus.doorbell_value !== want.doorbell_value)
               log_mismatch("doorbell_value", 64'(rsp_bus.doorbell_value),
                            64'(want.doorbell_value));
            if (rsp_bus.success !== want.success)
               log_mismatch("success", 64'(rsp_bus.success), 64'(want.success));
            if (rsp_bus.status_type !== want.status_type)
               log_mismatch("status_type", 64'(rsp_bus.status_type),
                            64'(want.status_type));
            if (rsp_bus.status_code !== want.status_code)
               log_mismatch("status_code", 64'(rsp_bus.status_code),
                            64'(want.status_code));
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin : stall_watch
      if (reset || csr_psel || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("nvme_io_queue_engine regression: fail");
            $finish;
         end
      end
   end

   // field extremes, reset namespace, zero count, phase mismatch, error status, reserved kind
   task automatic test_directed_entries();
      issue_host_item(make_item(nvq_pkg::REQ_READ, 64'd0, 16'h0000, 64'd0, 32'd0));
      issue_host_item(make_item(nvq_pkg::REQ_WRITE, '1, 16'hFFFF, '1, '1));
      issue_host_item(make_item(nvq_pkg::REQ_READ, 64'h0123_4567_89AB_CDEF, 16'h0001,
                                64'hAAAA_AAAA_AAAA_AAAA, 32'd0));
      issue_host_item(make_item(nvq_pkg::REQ_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h8000,
                                64'h5555_5555_5555_5555, 32'd0));
      issue_host_item(make_item(KIND_RESERVED, '1, 16'hFFFF, '1, 32'h0001_0000));
      // posted completion with clean status
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'h0001_0000));
      // stale phase: must be dropped
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'hFFFE_FFFF));
      // every status bit set
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'hFFFF_FFFF));
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'h0201_0000));
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'h0003_0000));
      // junk outside the status fields still means success
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'hF001_FFFF));
      // more completions than submissions outstanding
      issue_host_item(make_item(nvq_pkg::REQ_CPL, '0, '0, '0, 32'h0001_0000));
      issue_host_item(make_item(nvq_pkg::REQ_READ, 64'h8000_0000_0000_0000, 16'h7FFF,
                                64'h0000_0000_0000_0004, 32'd0));
   endtask

   // namespace register at its extremes and a few patterns
   task automatic test_namespace_values();
      logic [nvq_pkg::NS_W-1:0] settings [5];
      settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, $urandom};
      foreach (settings[i]) begin
         drain_queue_pair();
         write_namespace(settings[i]);
         repeat (6) issue_host_item(random_item($urandom_range(0, 99)));
      end
   endtask

   // fill past the ring size and consume enough to flip the phase twice
   task automatic test_ring_wrap();
      repeat (70) issue_host_item(random_item($urandom_range(0, 43)));
      repeat (135) issue_host_item(random_item(60));
   endtask

   // mixed traffic with idling switched on and off per block, one pause mid-way
   task automatic test_mixed_traffic();
      for (int blk = 0; blk < 8; blk++) begin
         src_idle_on = $urandom_range(0, 2) != 0;
         sink_idle_on = $urandom_range(0, 2) != 0;
         if (blk == 4) begin
            drain_queue_pair();
            write_namespace($urandom);
         end
         repeat (100) issue_host_item(random_item($urandom_range(0, 99)));
      end
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // closing stretch at full rate on both sides
   task automatic test_unthrottled_tail();
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      drain_queue_pair();
      write_namespace(nvq_pkg::NAMESPACE_RESET);
      repeat (120) issue_host_item(random_item($urandom_range(0, 99)));
   endtask

   initial begin
      reset                     = 1'b1;
      req_bus.valid             = 1'b0;
      req_bus.kind              = nvq_pkg::REQ_READ;
      req_bus.start_lba         = '0;
      req_bus.block_count       = '0;
      req_bus.buffer_addr       = '0;
      req_bus.completion_status = '0;
      rsp_bus.ready             = 1'b0;
      csr_psel                  = 1'b0;
      csr_penable               = 1'b0;
      csr_pwrite                = 1'b0;
      csr_paddr                 = '0;
      csr_pwdata                = '0;
      src_idle_on               = 1'b1;
      sink_idle_on              = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_entries();
      test_namespace_values();
      test_ring_wrap();
      test_mixed_traffic();
      test_unthrottled_tail();
      drain_queue_pair();

      $display("covered %0d request transactions: %0d entries issued, %0d completions taken",
               n_items, n_sub, n_cpl);
      $display("%0d error completions, %0d stale, %0d reserved, %0d phase flips, %0d ns writes",
               n_failed, n_stale, n_ignored, n_flips, n_ns_writes);
      if (n_errors == 0) begin
         $display("nvme_io_queue_engine regression: pass");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("nvme_io_queue_engine regression: fail");
      end
      $finish;
   end

endmodule
